// File: src/tmwf_pkg.sv
package tmwf_pkg;

    localparam int CHAN_W          = 3;
    localparam int SAMPLE_W        = 10;
    localparam int WINDOW_DEFAULT  = 16;
    localparam int CHANNELS_DEFAULT = 8;

    // trim points as percent of the window
    localparam int TRIM_LO_PCT = 15;
    localparam int TRIM_HI_PCT = 85;
    localparam int PCT_SCALE   = 100;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } rank_ctrl_t;

endpackage

// File: src/tmwf_ram.sv
module tmwf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/tmwf_rank.sv
module tmwf_rank #(
    parameter int WINDOW = tmwf_pkg::WINDOW_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmwf_pkg::rank_ctrl_t          ctrl,
    input  logic [tmwf_pkg::SAMPLE_W-1:0] din,
    output logic [tmwf_pkg::SAMPLE_W-1:0] head
);
    import tmwf_pkg::*;

    logic [SAMPLE_W-1:0] val_reg  [WINDOW];
    logic [SAMPLE_W-1:0] val_next [WINDOW];
    logic [WINDOW-1:0]   valid_reg;
    logic [WINDOW-1:0]   valid_next;
    logic [WINDOW-1:0]   gt;

    // entries above the insert point are larger or still empty; list stays ascending
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            gt[i] = !valid_reg[i] || (val_reg[i] > din);
        end
    end

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = '0;
        end
        else if (ctrl.insert)
        begin
            valid_next = {valid_reg[WINDOW-2:0], 1'b1};
            if (gt[0])
            begin
                val_next[0] = din;
            end
            for (int i = 1; i < WINDOW; i++)
            begin
                if (gt[i])
                begin
                    val_next[i] = gt[i-1] ? val_reg[i-1] : din;
                end
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = {1'b0, valid_reg[WINDOW-1:1]};
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                val_next[i] = val_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign head = val_reg[0];

endmodule

// File: src/tmwf_div.sv
module tmwf_div #(
    parameter int SW      = 14,
    parameter int DIVISOR = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [SW-1:0] dividend,
    output logic          done,
    output logic [SW-1:0] quotient
);
    localparam int DW = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int SH = SW + DW;
    localparam int MW = SH + 1;
    localparam longint unsigned RECIP =
        ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);

    logic [SW+MW-1:0] prod;
    logic [SW-1:0]    quo_reg;
    logic [SW-1:0]    quo_next;
    logic             done_reg;

    // floor division by a constant: multiply by the rounded-up reciprocal, exact for SW-bit inputs
    assign prod     = {{MW{1'b0}}, dividend} * {{SW{1'b0}}, MW'(RECIP)};
    assign quo_next = start ? prod[SH +: SW] : quo_reg;

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/trimmed_mean_window_filter_core.sv
// Trimmed-mean filter with one circular window of WINDOW samples per channel, kept in a
// single on-chip RAM. Each sample beat is written into its channel's window, the window is
// read back one word per cycle into an insertion-ranking register row, the ranks from
// the lower to the upper cut are summed, and the sum is divided by the kept count with a
// constant reciprocal multiply. One sample occupies the block from acceptance to the next
// in_ready through a write, the window read, the summing shifts, the multiply and the load
// of the output register, and longer while a previous result is still stalled there; a
// sample for a channel at or beyond CHANNELS skips the window and returns a zero result.
// After reset every RAM word is swept to zero before in_ready rises. A finished result
// waits in the output register while the next sample is worked on.
module trimmed_mean_window_filter_core #(
    parameter int WINDOW   = tmwf_pkg::WINDOW_DEFAULT,
    parameter int CHANNELS = tmwf_pkg::CHANNELS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmwf_pkg::CHAN_W-1:0]   channel,
    input  logic [tmwf_pkg::SAMPLE_W-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tmwf_pkg::CHAN_W-1:0]   channel_out,
    output logic [tmwf_pkg::SAMPLE_W-1:0] smoothed
);
    import tmwf_pkg::*;

    localparam int DEPTH     = CHANNELS * WINDOW;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW        = $clog2(WINDOW);
    localparam int CW        = $clog2(WINDOW + 1);
    localparam int CIW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW        = SAMPLE_W + $clog2(WINDOW);
    localparam int LOW_RAW   = (WINDOW * TRIM_LO_PCT) / PCT_SCALE;
    localparam int LOW_CUT   = (LOW_RAW > 1) ? LOW_RAW : 1;
    localparam int HIGH_RAW  = (WINDOW * TRIM_HI_PCT) / PCT_SCALE + 1;
    localparam int HIGH_CUT  = (HIGH_RAW < WINDOW - 1) ? HIGH_RAW : WINDOW - 1;
    localparam int KEEP      = HIGH_CUT - LOW_CUT;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_WRITE = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CHAN_W-1:0]   ch_reg, ch_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [IW-1:0]       slot_reg [CHANNELS];
    logic [IW-1:0]       slot_cur;
    logic [IW-1:0]       slot_new;
    logic                slot_we;
    logic [SW-1:0]       acc_reg, acc_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic                ovalid_reg, ovalid_next;
    logic [CHAN_W-1:0]   och_reg, och_next;
    logic [SAMPLE_W-1:0] omean_reg, omean_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [AW-1:0]       base;
    rank_ctrl_t          rank_ctrl;
    logic [SAMPLE_W-1:0] head;
    logic                div_start;
    logic                div_done;
    logic [SW-1:0]       div_quo;
    logic                ch_ok;
    logic                out_free;

    assign ch_ok    = 5'(channel) < 5'(CHANNELS);
    assign base     = AW'(ch_reg) * AW'(WINDOW);
    assign slot_cur = slot_reg[CIW'(ch_reg)];
    assign slot_new = (slot_cur == IW'(WINDOW - 1)) ? '0 : slot_cur + 1'b1;
    assign out_free = !ovalid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    tmwf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tmwf_rank #(
        .WINDOW (WINDOW)
    ) u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rank_ctrl),
        .din   (ram_rdata),
        .head  (head)
    );

    tmwf_div #(
        .SW      (SW),
        .DIVISOR (KEEP)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cnt_next    = cnt_reg;
        ch_next     = ch_reg;
        smp_next    = smp_reg;
        acc_next    = acc_reg;
        mean_next   = mean_reg;
        ovalid_next = ovalid_reg && !out_ready;
        och_next    = och_reg;
        omean_next  = omean_reg;
        slot_we     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = base + AW'(slot_new);
        ram_wdata   = smp_reg;
        ram_raddr   = base + AW'(cnt_reg);
        rank_ctrl   = '0;
        div_start   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next   = channel;
                    smp_next  = sample;
                    mean_next = '0;
                    state_next = ch_ok ? S_WRITE : S_DONE;
                end
            end
            S_WRITE:
            begin
                ram_we          = 1'b1;
                slot_we         = 1'b1;
                rank_ctrl.clear = 1'b1;
                cnt_next        = '0;
                state_next      = S_LOAD;
            end
            S_LOAD:
            begin
                // read data arrives in the cycle after its address
                rank_ctrl.insert = (cnt_reg != '0);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(WINDOW))
                begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                rank_ctrl.shift = 1'b1;
                if (cnt_reg >= CW'(LOW_CUT))
                begin
                    acc_next = acc_reg + SW'(head);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(HIGH_CUT - 1))
                begin
                    state_next = S_DIV;
                    div_start  = 1'b0;
                end
            end
            S_DIV:
            begin
                // start pulse on entry, then wait for the quotient
                div_start = (cnt_reg == CW'(HIGH_CUT));
                cnt_next  = '0;
                if (div_done)
                begin
                    mean_next  = div_quo[SAMPLE_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    och_next    = ch_reg;
                    omean_next  = mean_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        smp_reg   <= smp_next;
        acc_reg   <= acc_next;
        mean_reg  <= mean_next;
        och_reg   <= och_next;
        omean_reg <= omean_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            if (slot_we)
            begin
                slot_reg[CIW'(ch_reg)] <= slot_new;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign channel_out = och_reg;
    assign smoothed    = omean_reg;

endmodule

// File: src/tmwf_checker.sv
module tmwf_checker #(
    parameter int CHANNELS = tmwf_pkg::CHANNELS_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [tmwf_pkg::CHAN_W-1:0]   channel,
    input logic [tmwf_pkg::SAMPLE_W-1:0] sample,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tmwf_pkg::CHAN_W-1:0]   channel_out,
    input logic [tmwf_pkg::SAMPLE_W-1:0] smoothed
);
    import tmwf_pkg::*;

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(channel_out) && $stable(smoothed))
        else $error("result beat dropped or changed while stalled");

    // one sample in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in flight");

    // absent channels always report zero
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (5'(channel_out) >= 5'(CHANNELS)) |-> smoothed == '0)
        else $error("nonzero result for absent channel");

    // a result cannot appear in the cycle right after its sample is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result produced without processing time");

    // sample bus is only a payload here; keep it referenced
    logic unused_sample;
    assign unused_sample = ^sample;

endmodule

bind trimmed_mean_window_filter_core tmwf_checker #(.CHANNELS(CHANNELS)) u_tmwf_checker (.*);

// File: verif/trimmed_mean_window_filter_core_tb.sv
module trimmed_mean_window_filter_core_tb;

    import tmwf_pkg::*;

    localparam int WIN      = WINDOW_DEFAULT;
    localparam int NCHAN    = CHANNELS_DEFAULT;
    localparam int LOW_RAW  = (WIN * TRIM_LO_PCT) / PCT_SCALE;
    localparam int LOW_CUT  = (LOW_RAW > 1) ? LOW_RAW : 1;
    localparam int HIGH_RAW = (WIN * TRIM_HI_PCT) / PCT_SCALE + 1;
    localparam int HIGH_CUT = (HIGH_RAW < WIN - 1) ? HIGH_RAW : WIN - 1;
    localparam int N_RANDOM = 730;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] value;
    } filt_result_t;

    class trim_scoreboard;
        logic [SAMPLE_W-1:0] windows [NCHAN][WIN];
        int unsigned         slot [NCHAN];
        filt_result_t        pending [$];
        int                  errors;

        function new();
            foreach (windows[c, i]) windows[c][i] = '0;
            foreach (slot[c]) slot[c] = 0;
            errors = 0;
        endfunction

        function logic [SAMPLE_W-1:0] window_mean(int c);
            logic [SAMPLE_W-1:0] ranked [WIN];
            logic [SAMPLE_W-1:0] tmp;
            int unsigned total;
            int unsigned cnt;
            total = 0;
            cnt = 0;
            foreach (ranked[i]) ranked[i] = windows[c][i];
            for (int a = 1; a < WIN; a++)
                for (int b = a; b > 0 && ranked[b-1] > ranked[b]; b--)
                begin
                    tmp = ranked[b];
                    ranked[b] = ranked[b-1];
                    ranked[b-1] = tmp;
                end
            for (int a = LOW_CUT; a < HIGH_CUT; a++)
            begin
                total += ranked[a];
                cnt++;
            end
            return (cnt == 0) ? '0 : SAMPLE_W'(total / cnt);
        endfunction

        function void note_sample(logic [CHAN_W-1:0] c, logic [SAMPLE_W-1:0] s);
            filt_result_t r;
            r.chan = c;
            r.value = '0;
            if (c < NCHAN)
            begin
                slot[c] = (slot[c] + 1) % WIN;
                windows[c][slot[c]] = s;
                r.value = window_mean(c);
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [CHAN_W-1:0] c, logic [SAMPLE_W-1:0] v);
            filt_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: channel_out %0d smoothed %0d", c, v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (c !== e.chan)
            begin
                $error("channel_out: expected %0d, actual %0d", e.chan, c);
                errors++;
            end
            if (v !== e.value)
            begin
                $error("smoothed: expected %0d, actual %0d", e.value, v);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CHAN_W-1:0]   channel = '0;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHAN_W-1:0]   channel_out;
    logic [SAMPLE_W-1:0] smoothed;

    trim_scoreboard sb = new();
    bit   calm = 1'b0;
    int   cycles = 0;

    trimmed_mean_window_filter_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .channel(channel), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .channel_out(channel_out), .smoothed(smoothed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("trimmed_mean_window_filter_core_tb failed");
            $finish;
        end
    end

    // result side: random stall bursts, checked on every accepted beat
    initial
    begin
        int hold;
        hold = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (out_valid && out_ready)
                sb.check_result(channel_out, smoothed);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // valid stays up after acceptance until the next beat or idle burst updates it
    task automatic send_beat(logic [CHAN_W-1:0] c, logic [SAMPLE_W-1:0] s);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        channel <= c;
        sample <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_sample(c, s);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [CHAN_W-1:0]   c;
        logic [SAMPLE_W-1:0] s;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, channels 0, 1, 3, 4 and 7, fill one window
        send_beat(3'd0, 10'd0);
        send_beat(3'd0, 10'd1023);
        send_beat(3'd7, 10'd1023);
        send_beat(3'd7, 10'd0);
        send_beat(3'd3, 10'h2AA);
        send_beat(3'd4, 10'h155);
        for (int i = 0; i < 18; i++)
            send_beat(3'd1, (i % 3 == 0) ? 10'd1023 : SAMPLE_W'(i * 37));
        in_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            c = CHAN_W'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0: s = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                1: s = SAMPLE_W'(500 + $urandom_range(0, 40));
                default: s = SAMPLE_W'($urandom_range(0, 1023));
            endcase
            send_beat(c, s);
            if (n == 300)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            if (n == N_RANDOM - 120)
                calm = 1'b1;
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("trimmed_mean_window_filter_core_tb passed");
        else
            $display("trimmed_mean_window_filter_core_tb failed");
        $finish;
    end

endmodule

// File: sim.f
src/tmwf_pkg.sv
src/tmwf_ram.sv
src/tmwf_rank.sv
src/tmwf_div.sv
src/trimmed_mean_window_filter_core.sv
src/tmwf_checker.sv
verif/trimmed_mean_window_filter_core_tb.sv
